// File: design/mbrm_pkg.sv
// mbrm_pkg: widths, codes and the result word type for the modbus register map
// with change detection; used by the interfaces and every module but mbrm_ram, no dependencies
package mbrm_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 16;
  localparam int CNT_W     = 5;
  localparam int OP_W      = 3;
  localparam int AREA_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AREAS = 4;

  localparam logic [OP_W-1:0] OP_WRITE_BIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_WORD = 3'd1;
  localparam logic [OP_W-1:0] OP_READ       = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE       = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET_BASE = 3'd4;
  localparam logic [OP_W-1:0] OP_ADOPT      = 3'd5;

  localparam logic [AREA_W-1:0] AREA_COILS    = 2'd0;
  localparam logic [AREA_W-1:0] AREA_DISCRETE = 2'd1;
  localparam logic [AREA_W-1:0] AREA_HOLDING  = 2'd2;
  localparam logic [AREA_W-1:0] AREA_INPUT    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COIL_START      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCRETE_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCRETE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDING_START   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDING_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_REG_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_REG_COUNT = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [AREA_W-1:0] area;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
    logic              last;
  } res_t;

  function automatic logic is_bit_area(input logic [AREA_W-1:0] a);
    return (a == AREA_COILS) || (a == AREA_DISCRETE);
  endfunction

endpackage

// File: design/mbrm_item_if.sv
// mbrm_item_if: request channel carrying one operation word
// depends on mbrm_pkg for field widths
interface mbrm_item_if;
  logic                         valid;
  logic                         ready;
  logic [mbrm_pkg::OP_W-1:0]    opcode;
  logic [mbrm_pkg::AREA_W-1:0]  area;
  logic [mbrm_pkg::ADDR_W-1:0]  address;
  logic [mbrm_pkg::DATA_W-1:0]  value;

  modport source(output valid, opcode, area, address, value, input ready);
  modport sink(input valid, opcode, area, address, value, output ready);
endinterface

// File: design/mbrm_result_if.sv
// mbrm_result_if: result channel, one result word per handshake
// depends on mbrm_pkg for field widths
interface mbrm_result_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [mbrm_pkg::AREA_W-1:0]  out_area;
  logic [mbrm_pkg::ADDR_W-1:0]  out_address;
  logic [mbrm_pkg::DATA_W-1:0]  out_value;
  logic                         last;

  modport source(output valid, ok, out_area, out_address, out_value, last, input ready);
  modport sink(input valid, ok, out_area, out_address, out_value, last, output ready);
endinterface

// File: design/mbrm_cfg_if.sv
// mbrm_cfg_if: configuration write channel, register index and write data
// depends on mbrm_pkg for field widths
interface mbrm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbrm_pkg::CFG_IDX_W-1:0]  index;
  logic [mbrm_pkg::DATA_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/modbus_register_map_change_detect.sv
// modbus_register_map_change_detect: top level of the modbus register map with
// change detection; depends on mbrm_pkg, the three channel interfaces,
// mbrm_core and mbrm_out_reg
//
//   channel  dir   word
//   item     in    opcode, area, address, value
//   result   out   ok, out_area, out_address, out_value, last
//   cfg      in    index, data (register write)
//
// write, read, reset baseline and unused ops: one result each from the emit or
//   read data state; a read is bound by the value ram and its registered read
// take changes and adopt: sweep of 4 * AREA_DEPTH slots, one slot per ram read
// reset is synchronous; stores read as zero through valid bits, no clearing pass
// the output register lets a result wait while the next word is taken; a full
//   output register stalls the scan only when a further change must go out
module modbus_register_map_change_detect #(
  parameter int AREA_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  mbrm_item_if.sink     item,
  mbrm_result_if.source result,
  mbrm_cfg_if.sink      cfg
);

  logic           res_valid;
  logic           res_ready;
  mbrm_pkg::res_t res;

  mbrm_core #(.AREA_DEPTH(AREA_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  mbrm_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (res),
    .result   (result)
  );

endmodule

// File: design/mbrm_ram.sv
// mbrm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module mbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/mbrm_out_reg.sv
// mbrm_out_reg: output register between the core and the result channel
// depends on mbrm_pkg (res_t) and mbrm_result_if
module mbrm_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbrm_pkg::res_t       in_data,
  mbrm_result_if.source        result
);

  logic           valid;
  mbrm_pkg::res_t data;

  assign in_ready = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

  assign result.valid       = valid;
  assign result.ok          = data.ok;
  assign result.out_area    = data.area;
  assign result.out_address = data.address;
  assign result.out_value   = data.value;
  assign result.last        = data.last;

endmodule

// File: design/mbrm_core.sv
// mbrm_core: area configuration, value and shadow rams, valid bits and the
// sequencer for access, change scan and adopt; depends on mbrm_pkg, mbrm_ram, mbrm_item_if and mbrm_cfg_if
module mbrm_core #(
  parameter int AREA_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  mbrm_item_if.sink      item,
  mbrm_cfg_if.sink       cfg,
  output logic           res_valid,
  output mbrm_pkg::res_t res,
  input  logic           res_ready
);

  localparam int NUM_SLOTS = mbrm_pkg::NUM_AREAS * AREA_DEPTH;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int OFF_W     = (AREA_DEPTH > 1) ? $clog2(AREA_DEPTH) : 1;
  localparam int CNT_W     = mbrm_pkg::CNT_W;
  localparam int ADDR_W    = mbrm_pkg::ADDR_W;
  localparam int DATA_W    = mbrm_pkg::DATA_W;
  localparam int AREA_W    = mbrm_pkg::AREA_W;
  localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(AREA_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(AREA_DEPTH);
  localparam logic [AREA_W-1:0] AREA_LAST = mbrm_pkg::AREA_INPUT;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_EMIT  = 6'b000100,
    S_SW_RD = 6'b001000,
    S_SW_EV = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] start [mbrm_pkg::NUM_AREAS];
  logic [CNT_W-1:0]  count [mbrm_pkg::NUM_AREAS];
  logic [CNT_W-1:0]  eff   [mbrm_pkg::NUM_AREAS];

  logic [NUM_SLOTS-1:0]           vval;
  logic [NUM_SLOTS-1:0]           svalid;
  logic [mbrm_pkg::NUM_AREAS-1:0] baseline;

  logic [mbrm_pkg::OP_W-1:0] cur_op;
  logic [AREA_W-1:0]         cur_area;
  logic [ADDR_W-1:0]         cur_addr;
  logic                      hit;
  logic [SLOT_W-1:0]         slot_q;
  mbrm_pkg::res_t            rres;

  logic [AREA_W-1:0] sw_area;
  logic [OFF_W-1:0]  sw_off;
  logic              pend_valid;
  logic [AREA_W-1:0] pend_area;
  logic [ADDR_W-1:0] pend_addr;
  logic [DATA_W-1:0] pend_value;

  logic              item_fire;
  logic [ADDR_W:0]   in_diff;
  logic              in_hit;
  logic [OFF_W-1:0]  in_off;
  logic [SLOT_W-1:0] in_slot;
  logic              in_write;
  logic              kind_ok;
  logic [DATA_W-1:0] in_wdata;

  logic [SLOT_W-1:0] sw_slot;
  logic [ADDR_W:0]   sw_sum;
  logic              sw_exists;
  logic [DATA_W-1:0] sw_cur;
  logic              sw_differ;
  logic              sw_last;
  logic              emit_now;
  logic              advance;

  logic              val_we, val_re, sh_we, sh_re;
  logic [SLOT_W-1:0] val_raddr;
  logic [DATA_W-1:0] val_rdata, sh_rdata;

  always_comb begin
    for (int a = 0; a < mbrm_pkg::NUM_AREAS; a++) begin
      eff[a] = (count[a] > DEPTH_CNT) ? DEPTH_CNT : count[a];
    end
  end

  // request decode
  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_fire  = item.valid && item.ready;

  assign in_diff  = {1'b0, item.address} - {1'b0, start[item.area]};
  assign in_hit   = !in_diff[ADDR_W] && (in_diff[ADDR_W-1:0] < ADDR_W'(eff[item.area]));
  assign in_off   = in_diff[OFF_W-1:0];
  assign in_slot  = SLOT_W'(int'(item.area) * AREA_DEPTH + int'(in_off));
  assign in_write = (item.opcode == mbrm_pkg::OP_WRITE_BIT) ||
                    (item.opcode == mbrm_pkg::OP_WRITE_WORD);
  assign kind_ok  = (item.opcode == mbrm_pkg::OP_WRITE_BIT) ==
                    mbrm_pkg::is_bit_area(item.area);
  assign in_wdata = (item.opcode == mbrm_pkg::OP_WRITE_BIT) ?
                    {{(DATA_W-1){1'b0}}, (item.value != '0)} : item.value;

  // sweep over all slots
  assign sw_slot   = SLOT_W'(int'(sw_area) * AREA_DEPTH + int'(sw_off));
  assign sw_sum    = {1'b0, start[sw_area]} + (ADDR_W+1)'(sw_off);
  assign sw_exists = (CNT_W'(sw_off) < eff[sw_area]) && !sw_sum[ADDR_W];
  assign sw_cur    = vval[sw_slot] ? val_rdata : '0;
  assign sw_differ = !svalid[sw_slot] || (sh_rdata != sw_cur);
  assign sw_last   = (sw_area == AREA_LAST) && (sw_off == OFF_LAST);
  assign emit_now  = (cur_op == mbrm_pkg::OP_TAKE) && sw_exists && sw_differ &&
                     baseline[sw_area];
  assign advance   = !(emit_now && pend_valid && !res_ready);

  assign val_we    = item_fire && in_write && in_hit && kind_ok;
  assign val_re    = (item_fire && (item.opcode == mbrm_pkg::OP_READ)) || (state == S_SW_RD);
  assign val_raddr = (state == S_IDLE) ? in_slot : sw_slot;
  assign sh_re     = (state == S_SW_RD);
  assign sh_we     = (state == S_SW_EV) && advance && sw_exists &&
                     ((cur_op == mbrm_pkg::OP_ADOPT) || sw_differ);

  mbrm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (in_slot),
    .wdata (in_wdata),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  mbrm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_shadow_ram (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sw_slot),
    .wdata (sw_cur),
    .re    (sh_re),
    .raddr (sw_slot),
    .rdata (sh_rdata)
  );

  // result word towards the output register
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      S_EMIT: begin
        res_valid = 1'b1;
        res       = rres;
      end
      S_RD: begin
        res_valid   = 1'b1;
        res.ok      = hit;
        res.area    = cur_area;
        res.address = cur_addr;
        res.value   = (hit && vval[slot_q]) ? val_rdata : '0;
        res.last    = 1'b1;
      end
      S_SW_EV: begin
        res_valid   = emit_now && pend_valid;
        res.ok      = 1'b1;
        res.area    = pend_area;
        res.address = pend_addr;
        res.value   = pend_value;
      end
      S_FIN: begin
        res_valid = 1'b1;
        res.last  = 1'b1;
        if (cur_op == mbrm_pkg::OP_TAKE) begin
          res.ok = pend_valid;
          if (pend_valid) begin
            res.area    = pend_area;
            res.address = pend_addr;
            res.value   = pend_value;
          end
        end else begin
          res.ok = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      vval       <= '0;
      svalid     <= '0;
      baseline   <= '0;
      for (int a = 0; a < mbrm_pkg::NUM_AREAS; a++) begin
        start[a] <= '0;
        count[a] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          mbrm_pkg::REG_COIL_START:      start[mbrm_pkg::AREA_COILS]    <= cfg.data;
          mbrm_pkg::REG_COIL_COUNT:      count[mbrm_pkg::AREA_COILS]    <= cfg.data[CNT_W-1:0];
          mbrm_pkg::REG_DISCRETE_START:  start[mbrm_pkg::AREA_DISCRETE] <= cfg.data;
          mbrm_pkg::REG_DISCRETE_COUNT:  count[mbrm_pkg::AREA_DISCRETE] <= cfg.data[CNT_W-1:0];
          mbrm_pkg::REG_HOLDING_START:   start[mbrm_pkg::AREA_HOLDING]  <= cfg.data;
          mbrm_pkg::REG_HOLDING_COUNT:   count[mbrm_pkg::AREA_HOLDING]  <= cfg.data[CNT_W-1:0];
          mbrm_pkg::REG_INPUT_REG_START: start[mbrm_pkg::AREA_INPUT]    <= cfg.data;
          mbrm_pkg::REG_INPUT_REG_COUNT: count[mbrm_pkg::AREA_INPUT]    <= cfg.data[CNT_W-1:0];
          default: ;
        endcase
        vval     <= '0;
        svalid   <= '0;
        baseline <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_fire) begin
            cur_op     <= item.opcode;
            cur_area   <= item.area;
            cur_addr   <= item.address;
            hit        <= in_hit;
            slot_q     <= in_slot;
            sw_area    <= '0;
            sw_off     <= '0;
            pend_valid <= 1'b0;
            unique case (item.opcode)
              mbrm_pkg::OP_WRITE_BIT, mbrm_pkg::OP_WRITE_WORD: begin
                rres <= '{ok: in_hit && kind_ok, area: item.area, address: item.address,
                          value: '0, last: 1'b1};
                if (val_we) begin
                  vval[in_slot] <= 1'b1;
                end
                state <= S_EMIT;
              end
              mbrm_pkg::OP_READ: begin
                state <= S_RD;
              end
              mbrm_pkg::OP_TAKE, mbrm_pkg::OP_ADOPT: begin
                state <= S_SW_RD;
              end
              mbrm_pkg::OP_RESET_BASE: begin
                svalid   <= '0;
                baseline <= '0;
                rres     <= '{ok: 1'b1, area: '0, address: '0, value: '0, last: 1'b1};
                state    <= S_EMIT;
              end
              default: begin
                rres  <= '{ok: 1'b0, area: '0, address: '0, value: '0, last: 1'b1};
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_RD, S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_SW_RD: begin
          state <= S_SW_EV;
        end
        S_SW_EV: begin
          if (advance) begin
            if (cur_op == mbrm_pkg::OP_ADOPT) begin
              svalid[sw_slot] <= sw_exists;
            end else if (!sw_exists) begin
              svalid[sw_slot] <= 1'b0;
            end else if (sw_differ) begin
              svalid[sw_slot] <= 1'b1;
              if (baseline[sw_area]) begin
                pend_valid <= 1'b1;
                pend_area  <= sw_area;
                pend_addr  <= sw_sum[ADDR_W-1:0];
                pend_value <= sw_cur;
              end
            end
            if (sw_last) begin
              state <= S_FIN;
            end else begin
              if (sw_off == OFF_LAST) begin
                sw_off  <= '0;
                sw_area <= sw_area + 1'b1;
              end else begin
                sw_off <= sw_off + 1'b1;
              end
              state <= S_SW_RD;
            end
          end
        end
        S_FIN: begin
          if (res_ready) begin
            baseline   <= '1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_read_goes_to_rd: assert property (@(posedge clk) disable iff (rst)
    (item_fire && (item.opcode == mbrm_pkg::OP_READ)) |=> (state == S_RD))
    else $error("read request did not move to read data state");

  a_scan_words_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_EV && res_valid) |-> (res.ok && !res.last && pend_valid))
    else $error("scan emitted a word that is not a pending change");

  a_pend_in_sweep: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_SW_RD || state == S_SW_EV || state == S_FIN))
    else $error("pending change held outside a sweep");

  a_baseline_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_ready) |=> (baseline == '1))
    else $error("baselines not set after scan or adopt");
`endif

endmodule
